>>> rtl/assert_macros.svh
// Assertion macros used by the directory back end (hdd_back).
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define HD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define HD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/hdd_pkg.sv
// Shared types and constants for the dual-key directory.
// No dependencies.
`default_nettype none
package hdd_pkg;
  localparam int TABLE_SIZE_DEF = 17;
  localparam int NAME_W = 56;
  localparam int TEL_W = 44;
  localparam int ADDR_W = 64;
  localparam int ADDRH_W = 24;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND_NAME = 2'd1,
    KIND_FIND_TEL = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NAME_FULL = 2'd2,
    ST_TEL_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NAME_PROBE,
    BK_TEL_PROBE,
    BK_COMMIT,
    BK_FIND,
    BK_FIND_CMP,
    BK_READ,
    BK_OUT
  } bk_state_t;
endpackage
`default_nettype wire

>>> rtl/hdd_front.sv
// Front end: accepts items, computes both home slots, pushes to a 2-entry queue.
// Depends on hdd_pkg.
`default_nettype none
module hdd_front #(
  parameter int TABLE_SIZE = hdd_pkg::TABLE_SIZE_DEF,
  localparam int IW = $clog2(TABLE_SIZE),
  localparam int QW = 2 + hdd_pkg::NAME_W + hdd_pkg::TEL_W + 2 * hdd_pkg::ADDR_W
                      + hdd_pkg::ADDRH_W + 2 * IW
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   kind,
  input  wire logic [hdd_pkg::NAME_W-1:0]   name_key,
  input  wire logic [hdd_pkg::TEL_W-1:0]    tel_digits,
  input  wire logic [hdd_pkg::ADDR_W-1:0]   address_low,
  input  wire logic [hdd_pkg::ADDR_W-1:0]   address_mid,
  input  wire logic [hdd_pkg::ADDRH_W-1:0]  address_high,
  output logic                              q_valid,
  input  wire logic                         q_ready,
  output logic [QW-1:0]                     q_data
);
  logic [QW-1:0] mem [2];
  logic          wp, rp;
  logic [1:0]    cnt;
  logic [8:0]    nsum;
  logic [7:0]    tsum;
  logic [IW-1:0] nhome, thome;

  // home = sum mod TABLE_SIZE; sums < 511, done by a small loop of compares
  always_comb begin
    logic [8:0] a;
    logic [7:0] b;
    nsum = {1'b0, name_key[7:0]} + {1'b0, name_key[15:8]};
    tsum = 8'(tel_digits[7:4]) * 8'd10 + 8'(tel_digits[3:0]);
    a = nsum;
    b = tsum;
    for (int s = 8; s >= 0; s--) begin
      if ((s < 9) && ({5'b0, a} >= (14'(TABLE_SIZE) << s)))
        a = 9'({5'b0, a} - (14'(TABLE_SIZE) << s));
      if ((s < 8) && ({6'b0, b} >= (14'(TABLE_SIZE) << s)))
        b = 8'({6'b0, b} - (14'(TABLE_SIZE) << s));
    end
    nhome = IW'(a);
    thome = IW'(b);
  end

  assign in_ready = (cnt != 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_data = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      mem[wp] <= {kind, name_key, tel_digits, address_low, address_mid, address_high,
                  nhome, thome};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule
`default_nettype wire

>>> rtl/hdd_back.sv
// Back end: probes the two hash tables slot by slot, reads or writes records.
// Depends on hdd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module hdd_back #(
  parameter int TABLE_SIZE = hdd_pkg::TABLE_SIZE_DEF,
  localparam int IW = $clog2(TABLE_SIZE),
  localparam int QW = 2 + hdd_pkg::NAME_W + hdd_pkg::TEL_W + 2 * hdd_pkg::ADDR_W
                      + hdd_pkg::ADDRH_W + 2 * IW
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  output logic                              q_ready,
  input  wire logic [QW-1:0]                q_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        status,
  output logic [hdd_pkg::NAME_W-1:0]        found_name,
  output logic [hdd_pkg::TEL_W-1:0]         found_tel,
  output logic [hdd_pkg::ADDR_W-1:0]        found_address_low,
  output logic [hdd_pkg::ADDR_W-1:0]        found_address_mid,
  output logic [hdd_pkg::ADDRH_W-1:0]       found_address_high
);
  localparam int CW = $clog2(TABLE_SIZE + 1);

  // record store: one read and one write port, read data registered
  logic [hdd_pkg::NAME_W-1:0]  rec_name      [TABLE_SIZE];
  logic [hdd_pkg::TEL_W-1:0]   rec_tel       [TABLE_SIZE];
  logic [hdd_pkg::ADDR_W-1:0]  rec_addr_low  [TABLE_SIZE];
  logic [hdd_pkg::ADDR_W-1:0]  rec_addr_mid  [TABLE_SIZE];
  logic [hdd_pkg::ADDRH_W-1:0] rec_addr_high [TABLE_SIZE];
  logic [IW-1:0] name_ref [TABLE_SIZE];
  logic [IW-1:0] tel_ref  [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] name_used, tel_used;
  logic [CW-1:0] record_count;

  hdd_pkg::bk_state_t state, state_next;
  logic [1:0]                  kind_r;
  logic [hdd_pkg::NAME_W-1:0]  nkey;
  logic [hdd_pkg::TEL_W-1:0]   tkey;
  logic [hdd_pkg::ADDR_W-1:0]  alow, amid;
  logic [hdd_pkg::ADDRH_W-1:0] ahigh;
  logic [IW-1:0] nhome, thome;
  logic [IW-1:0] pos, pos_next, nslot;
  logic [CW-1:0] step;
  logic [IW-1:0] ridx;
  logic [hdd_pkg::NAME_W-1:0]  rd_name;
  logic [hdd_pkg::TEL_W-1:0]   rd_tel;
  logic [hdd_pkg::ADDR_W-1:0]  rd_low, rd_mid;
  logic [hdd_pkg::ADDRH_W-1:0] rd_high;
  logic by_tel;
  logic cur_used;
  logic last_step;

  // pos + step + 1 mod TABLE_SIZE; only used while step < TABLE_SIZE-1
  always_comb begin
    logic [CW:0] s;
    s = (CW+1)'(pos) + (CW+1)'(step) + (CW+1)'(1);
    if (s >= (CW+1)'(TABLE_SIZE)) s = s - (CW+1)'(TABLE_SIZE);
    pos_next = IW'(s);
  end
  assign last_step = (step == CW'(TABLE_SIZE - 1));
  assign by_tel = (kind_r == hdd_pkg::KIND_FIND_TEL);
  assign cur_used = by_tel ? tel_used[pos] : name_used[pos];
  assign q_ready = (state == hdd_pkg::BK_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= hdd_pkg::BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      hdd_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (hdd_pkg::kind_t'(q_data[QW-1 -: 2]))
            hdd_pkg::KIND_INSERT: state_next = hdd_pkg::BK_NAME_PROBE;
            hdd_pkg::KIND_FIND_NAME, hdd_pkg::KIND_FIND_TEL: state_next = hdd_pkg::BK_FIND;
            default: state_next = hdd_pkg::BK_OUT;
          endcase
        end
      end
      hdd_pkg::BK_NAME_PROBE: begin
        if (!name_used[pos]) state_next = hdd_pkg::BK_TEL_PROBE;
        else if (last_step) state_next = hdd_pkg::BK_OUT;
      end
      hdd_pkg::BK_TEL_PROBE: begin
        if (!tel_used[pos]) begin
          if (record_count >= CW'(TABLE_SIZE)) state_next = hdd_pkg::BK_OUT;
          else state_next = hdd_pkg::BK_COMMIT;
        end else if (last_step) state_next = hdd_pkg::BK_OUT;
      end
      hdd_pkg::BK_COMMIT: state_next = hdd_pkg::BK_OUT;
      hdd_pkg::BK_FIND: begin
        if (!cur_used) begin
          if (step == '0 || last_step) state_next = hdd_pkg::BK_OUT;
        end else state_next = hdd_pkg::BK_FIND_CMP;
      end
      hdd_pkg::BK_FIND_CMP: begin
        if (by_tel ? (rd_tel == tkey) : (rd_name == nkey)) state_next = hdd_pkg::BK_READ;
        else if (last_step) state_next = hdd_pkg::BK_OUT;
        else state_next = hdd_pkg::BK_FIND;
      end
      hdd_pkg::BK_READ: state_next = hdd_pkg::BK_OUT;
      hdd_pkg::BK_OUT: if (out_ready) state_next = hdd_pkg::BK_IDLE;
      default: state_next = hdd_pkg::BK_IDLE;
    endcase
  end

  assign out_valid = (state == hdd_pkg::BK_OUT);

  // record store read port
  always_ff @(posedge clk) begin
    rd_name <= rec_name[ridx];
    rd_tel <= rec_tel[ridx];
    rd_low <= rec_addr_low[ridx];
    rd_mid <= rec_addr_mid[ridx];
    rd_high <= rec_addr_high[ridx];
    if (state == hdd_pkg::BK_COMMIT) begin
      rec_name[IW'(record_count)] <= nkey;
      rec_tel[IW'(record_count)] <= tkey;
      rec_addr_low[IW'(record_count)] <= alow;
      rec_addr_mid[IW'(record_count)] <= amid;
      rec_addr_high[IW'(record_count)] <= ahigh;
      name_ref[nslot] <= IW'(record_count);
      tel_ref[pos] <= IW'(record_count);
    end
  end
  assign ridx = by_tel ? tel_ref[pos] : name_ref[pos];

  always_ff @(posedge clk) begin
    if (rst) begin
      name_used <= '0;
      tel_used <= '0;
      record_count <= '0;
    end else if (state == hdd_pkg::BK_COMMIT) begin
      name_used[nslot] <= 1'b1;
      tel_used[pos] <= 1'b1;
      record_count <= record_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      hdd_pkg::BK_IDLE: begin
        {kind_r, nkey, tkey, alow, amid, ahigh, nhome, thome} <= q_data;
        pos <= (q_data[QW-1 -: 2] == hdd_pkg::KIND_FIND_TEL) ? q_data[IW-1:0]
                                                            : q_data[2*IW-1:IW];
        step <= '0;
        status <= hdd_pkg::ST_NOT_FOUND;
        found_name <= '0;
        found_tel <= '0;
        found_address_low <= '0;
        found_address_mid <= '0;
        found_address_high <= '0;
      end
      hdd_pkg::BK_NAME_PROBE: begin
        if (!name_used[pos]) begin
          nslot <= pos;
          pos <= thome;
          step <= '0;
        end else if (last_step) status <= hdd_pkg::ST_NAME_FULL;
        else begin
          pos <= pos_next;
          step <= step + CW'(1);
        end
      end
      hdd_pkg::BK_TEL_PROBE: begin
        if (!tel_used[pos]) begin
          if (record_count >= CW'(TABLE_SIZE)) status <= hdd_pkg::ST_NAME_FULL;
        end else if (last_step) status <= hdd_pkg::ST_TEL_FULL;
        else begin
          pos <= pos_next;
          step <= step + CW'(1);
        end
      end
      hdd_pkg::BK_COMMIT: status <= hdd_pkg::ST_OK;
      hdd_pkg::BK_FIND: begin
        if (!cur_used && !last_step && step != '0) begin
          pos <= pos_next;
          step <= step + CW'(1);
        end
      end
      hdd_pkg::BK_FIND_CMP: begin
        if (!(by_tel ? (rd_tel == tkey) : (rd_name == nkey)) && !last_step) begin
          pos <= pos_next;
          step <= step + CW'(1);
        end
      end
      hdd_pkg::BK_READ: begin
        status <= hdd_pkg::ST_OK;
        found_name <= rd_name;
        found_tel <= rd_tel;
        found_address_low <= rd_low;
        found_address_mid <= rd_mid;
        found_address_high <= rd_high;
      end
      default: ;
    endcase
  end

  `HD_ASSERT_IMP(a_count_range, clk, rst, 1'b1, record_count <= CW'(TABLE_SIZE))
  `HD_ASSERT_IMP(a_step_range, clk, rst, state != hdd_pkg::BK_IDLE,
                 step <= CW'(TABLE_SIZE - 1))
  `HD_ASSERT_NXT(a_commit_grows, clk, rst, state == hdd_pkg::BK_COMMIT,
                 record_count == $past(record_count) + CW'(1))
endmodule
`default_nettype wire

>>> rtl/hash_directory_dual_key.sv
// Top level of the dual-key directory: front queue plus probing back end.
// Depends on hdd_pkg, hdd_front, hdd_back.
// An item is accepted into a two-entry queue while the back end works on the
// previous one. The back end handles one item at a time: an insert probes the
// name table one slot per cycle (home, +1, +3, +6, ...), then the phone
// table, then writes the record; it stops early when a table is full. A
// lookup visits slots in the same order, reading each occupied slot and then
// comparing its record, and reads the record out on a match. The record
// store has one read and one write port, and the probe walk is serial. Stores
// are empty after reset with no clearing pass. One result item follows each
// input item.
`default_nettype none
module hash_directory_dual_key #(
  parameter int TABLE_SIZE = hdd_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   kind,
  input  wire logic [hdd_pkg::NAME_W-1:0]   name_key,
  input  wire logic [hdd_pkg::TEL_W-1:0]    tel_digits,
  input  wire logic [hdd_pkg::ADDR_W-1:0]   address_low,
  input  wire logic [hdd_pkg::ADDR_W-1:0]   address_mid,
  input  wire logic [hdd_pkg::ADDRH_W-1:0]  address_high,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        status,
  output logic [hdd_pkg::NAME_W-1:0]        found_name,
  output logic [hdd_pkg::TEL_W-1:0]         found_tel,
  output logic [hdd_pkg::ADDR_W-1:0]        found_address_low,
  output logic [hdd_pkg::ADDR_W-1:0]        found_address_mid,
  output logic [hdd_pkg::ADDRH_W-1:0]       found_address_high
);
  localparam int IW = $clog2(TABLE_SIZE);
  localparam int QW = 2 + hdd_pkg::NAME_W + hdd_pkg::TEL_W + 2 * hdd_pkg::ADDR_W
                      + hdd_pkg::ADDRH_W + 2 * IW;

  logic          q_valid, q_ready;
  logic [QW-1:0] q_data;

  // front: hashing and queue
  hdd_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
    .clk, .rst, .in_valid, .in_ready, .kind, .name_key, .tel_digits,
    .address_low, .address_mid, .address_high, .q_valid, .q_ready, .q_data
  );

  // back: probing, record store, result register
  hdd_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data, .out_valid, .out_ready, .status,
    .found_name, .found_tel, .found_address_low, .found_address_mid,
    .found_address_high
  );
endmodule
`default_nettype wire
